// ===== design/fbd_pkg.sv =====
package fbd_pkg;
   localparam int unsigned MaxMultiplierDefault = 15;
   localparam int unsigned DivisorLimitDefault  = 65536;
   localparam int unsigned ClockWidth = 30;
   localparam int unsigned BaudWidth  = 24;
   localparam int unsigned DivWidth   = 16;
   localparam int unsigned MulWidth   = 4;
   localparam int unsigned ClockShift = 4;
   localparam int unsigned UclkWidth  = ClockWidth - ClockShift;
   localparam int unsigned NumWidth   = UclkWidth + MulWidth;
   localparam int unsigned DenWidth   = MulWidth + 1;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;
endpackage

// ===== design/fbd_divider.sv =====
module fbd_divider
   import fbd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NumWidth-1:0] dividend,
   input  logic [NumWidth-1:0] divisor,
   output div_ctl_type         status,
   output logic [NumWidth-1:0] quotient,
   output logic [NumWidth-1:0] remainder
);
   localparam int unsigned CntWidth = $clog2(NumWidth + 1);

   logic [NumWidth-1:0] quo_ff, quo_in;
   logic [NumWidth-1:0] rem_ff, rem_in;
   logic [NumWidth-1:0] den_ff, den_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [NumWidth:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[NumWidth-1]} - {1'b0, den_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CntWidth'(NumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[NumWidth]) begin
            rem_in = trial[NumWidth-1:0];
            quo_in = {quo_ff[NumWidth-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[NumWidth-2:0], quo_ff[NumWidth-1]};
            quo_in = {quo_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.start = start;
   assign status.busy  = busy_ff;
   assign status.done  = done_ff;
   assign quotient     = quo_ff;
   assign remainder    = rem_ff;
endmodule

// ===== design/fractional_baud_divider_search_core.sv =====
// Channel | Direction | Signals
// req     | in        | req_valid, req_stall, req_core_clock, req_target_baud
// rsp     | out       | rsp_valid, rsp_stall, rsp_divisor, rsp_multiplier,
//         |           | rsp_divide_add, rsp_baud_error, rsp_found
// Each (mul, dadd) pair runs up to three 30-step divisions on one shared
// restoring divider; the third is skipped when the rounded divisor is zero
// or reaches DIVISOR_LIMIT. A zero target baud skips the search.
// reset is synchronous; req_stall is high while a search runs or a result
// waits. A stalled result holds until rsp_stall drops.
module fractional_baud_divider_search_core
   import fbd_pkg::*;
#(
   parameter int unsigned MAX_MULTIPLIER = MaxMultiplierDefault,
   parameter int unsigned DIVISOR_LIMIT  = DivisorLimitDefault
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ClockWidth-1:0] req_core_clock,
   input  logic [BaudWidth-1:0]  req_target_baud,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DivWidth-1:0]   rsp_divisor,
   output logic [MulWidth-1:0]   rsp_multiplier,
   output logic [MulWidth-1:0]   rsp_divide_add,
   output logic [BaudWidth-1:0]  rsp_baud_error,
   output logic                  rsp_found
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PAIR = 3'd1;
   localparam logic [2:0] S_FRAC = 3'd2;
   localparam logic [2:0] S_DV   = 3'd3;
   localparam logic [2:0] S_ACH  = 3'd4;
   localparam logic [2:0] S_NEXT = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [UclkWidth-1:0]  uclk_ff, uclk_in;
   logic [BaudWidth-1:0]  baud_ff, baud_in;
   logic [MulWidth-1:0]   mul_ff, mul_in;
   logic [MulWidth-1:0]   add_ff, add_in;
   logic [NumWidth-1:0]   frac_ff, frac_in;
   logic [NumWidth-1:0]   dv_ff, dv_in;
   logic [BaudWidth-1:0]  best_err_ff, best_err_in;
   logic [DivWidth-1:0]   best_div_ff, best_div_in;
   logic [MulWidth-1:0]   best_mul_ff, best_mul_in;
   logic [MulWidth-1:0]   best_add_ff, best_add_in;
   logic                  hit_ff, hit_in;
   logic                  go;
   logic [NumWidth-1:0]   div_a, div_b, quo, rem;
   div_ctl_type           div_st;
   logic [NumWidth-1:0]   dv_round;
   logic [NumWidth-1:0]   err_full;

   fbd_divider u_div (
      .clock(clock), .reset(reset), .start(go), .dividend(div_a),
      .divisor(div_b), .status(div_st), .quotient(quo), .remainder(rem)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      dv_round = quo + NumWidth'(rem >= NumWidth'(baud_ff >> 1));
      if (quo >= NumWidth'(baud_ff)) err_full = quo - NumWidth'(baud_ff);
      else                           err_full = NumWidth'(baud_ff) - quo;
   end

   always_comb begin
      state_in    = state_ff;
      uclk_in     = uclk_ff;
      baud_in     = baud_ff;
      mul_in      = mul_ff;
      add_in      = add_ff;
      frac_in     = frac_ff;
      dv_in       = dv_ff;
      best_err_in = best_err_ff;
      best_div_in = best_div_ff;
      best_mul_in = best_mul_ff;
      best_add_in = best_add_ff;
      hit_in      = hit_ff;
      go          = 1'b0;
      div_a       = NumWidth'(uclk_ff) * NumWidth'(mul_ff);
      div_b       = NumWidth'(mul_ff) + NumWidth'(add_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               uclk_in     = req_core_clock[ClockWidth-1:ClockShift];
               baud_in     = req_target_baud;
               mul_in      = MulWidth'(1);
               add_in      = '0;
               best_err_in = req_target_baud;
               best_div_in = '0;
               best_mul_in = '0;
               best_add_in = '0;
               hit_in      = 1'b0;
               state_in    = (req_target_baud == '0) ? S_OUT : S_PAIR;
            end
         end
         S_PAIR: begin
            go       = 1'b1;
            state_in = S_FRAC;
         end
         S_FRAC: begin
            div_a = quo;
            div_b = NumWidth'(baud_ff);
            if (div_st.done) begin
               frac_in  = quo;
               go       = 1'b1;
               state_in = S_DV;
            end
         end
         S_DV: begin
            div_a = frac_ff;
            div_b = dv_round;
            if (div_st.done) begin
               dv_in = dv_round;
               if (dv_round == '0 || dv_round >= NumWidth'(DIVISOR_LIMIT)) begin
                  state_in = S_NEXT;
               end else begin
                  go       = 1'b1;
                  state_in = S_ACH;
               end
            end
         end
         S_ACH: begin
            if (div_st.done) begin
               if (err_full < NumWidth'(best_err_ff)) begin
                  best_err_in = err_full[BaudWidth-1:0];
                  best_div_in = dv_ff[DivWidth-1:0];
                  best_mul_in = mul_ff;
                  best_add_in = add_ff;
                  hit_in      = 1'b1;
               end
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (add_ff == mul_ff - 1'b1) begin
               add_in = '0;
               mul_in = mul_ff + 1'b1;
               state_in = (mul_ff == MulWidth'(MAX_MULTIPLIER)) ? S_OUT : S_PAIR;
            end else begin
               add_in   = add_ff + 1'b1;
               state_in = S_PAIR;
            end
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      uclk_ff     <= uclk_in;
      baud_ff     <= baud_in;
      mul_ff      <= mul_in;
      add_ff      <= add_in;
      frac_ff     <= frac_in;
      dv_ff       <= dv_in;
      best_err_ff <= best_err_in;
      best_div_ff <= best_div_in;
      best_mul_ff <= best_mul_in;
      best_add_ff <= best_add_in;
      hit_ff      <= hit_in;
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign rsp_divisor    = best_div_ff;
   assign rsp_multiplier = best_mul_ff;
   assign rsp_divide_add = best_add_ff;
   assign rsp_baud_error = best_err_ff;
   assign rsp_found      = hit_ff;
endmodule

// ===== design/fbd_checker.sv =====
module fbd_checker
   import fbd_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [DivWidth-1:0]  rsp_divisor,
   input logic [MulWidth-1:0]  rsp_multiplier,
   input logic [MulWidth-1:0]  rsp_divide_add,
   input logic [BaudWidth-1:0] rsp_baud_error,
   input logic                 rsp_found
);
   a_busy_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("ready while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_divisor)
      && $stable(rsp_baud_error)) else $error("stalled result changed");
   a_no_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_divisor == '0 && rsp_multiplier == '0
      && rsp_divide_add == '0) else $error("empty result not zero");
   a_found_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_divisor != '0 && rsp_multiplier != '0
      && rsp_divide_add < rsp_multiplier) else $error("bad found result");
   a_accept_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("no stall after accept");
endmodule

bind fractional_baud_divider_search_core fbd_checker u_fbd_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_divisor(rsp_divisor),
   .rsp_multiplier(rsp_multiplier), .rsp_divide_add(rsp_divide_add),
   .rsp_baud_error(rsp_baud_error), .rsp_found(rsp_found)
);
